// ===== hw/rtl/komt_pkg.sv =====
// Shared constants and types for the keyed observation merge table.
`timescale 1ns / 1ps
package komt_pkg;
    localparam int TABLE_DEPTH  = 64;
    localparam int SENSOR_COUNT = 16;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W  = 48;
    localparam int MASK_W = 16;
    localparam int PAY_W  = 16 + 32 + 32 + 32 + 8 + 16 + 8 + 5;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [31:0]       obs;
        logic [31:0]       first;
        logic [31:0]       last;
        logic [7:0]        chan;
        logic [15:0]       freq;
        logic signed [7:0] rssi;
        logic signed [4:0] bsensor;
    } entry_t;
endpackage

// ===== hw/rtl/komt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module komt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/komt_search.sv =====
// Key search: sweeps the key memory one slot per cycle looking for a match.
`timescale 1ns / 1ps
module komt_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [komt_pkg::KEY_W-1:0]    key,
    input  logic [komt_pkg::CNT_W-1:0]    count,
    input  logic                          kwe,
    input  logic [komt_pkg::IDX_W-1:0]    kwaddr,
    output logic                          done,
    output logic                          found,
    output logic [komt_pkg::IDX_W-1:0]    hit_idx
);
    import komt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CHECK} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  chk_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  rkey;
    logic              done_reg, found_reg;
    logic [IDX_W-1:0]  hit_reg;

    komt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(key_reg),
        .raddr(ptr_reg[IDX_W-1:0]), .rdata(rkey)
    );

    // Scan: issue read at ptr, compare the slot whose read was issued in the previous cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            chk_reg   <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            hit_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        key_reg <= key;
                        ptr_reg <= '0;
                        if (count == '0)
                        begin
                            done_reg  <= 1'b1;
                            found_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    chk_reg   <= ptr_reg;
                    ptr_reg   <= ptr_reg + 1'b1;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (rkey == key_reg)
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b1;
                        hit_reg   <= chk_reg[IDX_W-1:0];
                        state_reg <= S_IDLE;
                    end
                    else if (ptr_reg >= count)
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        chk_reg <= ptr_reg;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign found   = found_reg;
    assign hit_idx = hit_reg;
endmodule

// ===== hw/rtl/keyed_observation_merge_table_core.sv =====
// Top level of the keyed observation merge table.
`timescale 1ns / 1ps
// Usage: raise start with one observation on the input ports while busy is
// low; the item is taken at that edge and busy stays high until its result
// has gone out. Exactly one result per item appears for one cycle with valid
// high; the receiver cannot stall it. Dropped items show accepted low, all
// entry fields zero and the updated drop_count.
// Search: the key memory is swept one slot per cycle, up to the hit or, on a
// miss, up to the entry count. A merged item then passes through the READ
// and MERGE states and the result register; a new key on a full table goes
// from the search to the DROP state, and an out-of-range sensor goes straight
// to the DROP state. No new item is taken before the last result is out.
// The payload memory is read in the READ state; the entry is merged and
// written back in the MERGE state.
// Items are handled one at a time, so no entry access overlaps another.
// Reset clears the entry count and the drop counter; memory contents need
// no clearing since only data from slots below the entry count is ever used.
module keyed_observation_merge_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  sensor_num,
    input  logic [47:0] station_key,
    input  logic [7:0]  channel_num,
    input  logic [15:0] freq_in,
    input  logic signed [7:0] rssi_in,
    input  logic [31:0] timestamp,
    output logic        valid,
    output logic        accepted,
    output logic [5:0]  entry_index,
    output logic [15:0] seen_mask,
    output logic [4:0]  seen_by,
    output logic [31:0] observation_count,
    output logic [31:0] first_time,
    output logic [31:0] last_time,
    output logic [7:0]  stored_channel,
    output logic [15:0] stored_freq,
    output logic signed [7:0] peak_rssi,
    output logic signed [4:0] peak_sensor,
    output logic [31:0] drop_count
);
    import komt_pkg::*;

    typedef enum logic [2:0] {T_IDLE, T_SEARCH, T_READ, T_MERGE, T_DROP} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       drops_reg;
    logic [7:0]        sens_reg;
    logic [7:0]        chan_reg;
    logic [15:0]       freq_reg;
    logic signed [7:0] rssi_reg;
    logic [31:0]       ts_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              new_reg;
    logic              valid_reg, acc_reg;
    entry_t            out_reg;

    logic              s_done, s_found;
    logic [IDX_W-1:0]  s_idx;
    logic              go;
    entry_t            rd_entry, base, merged;
    logic              pwe, kwe;

    assign go = start && !busy && (sensor_num < 8'(SENSOR_COUNT));

    komt_search u_search (
        .clk(clk), .rst_n(rst_n), .go(go), .key(station_key), .count(count_reg),
        .kwe(kwe), .kwaddr(idx_reg), .done(s_done), .found(s_found), .hit_idx(s_idx)
    );

    komt_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_DEPTH)) u_pay (
        .clk(clk), .we(pwe), .waddr(idx_reg), .wdata(merged),
        .raddr(idx_reg), .rdata(rd_entry)
    );

    assign pwe = (state_reg == T_MERGE);
    assign kwe = pwe && new_reg;

    // Merge the observation into the entry (fresh values on insertion).
    always_comb
    begin
        if (new_reg)
        begin
            base         = '0;
            base.first   = ts_reg;
            base.bsensor = -5'sd1;
        end
        else
        begin
            base = rd_entry;
        end
        merged       = base;
        merged.mask  = base.mask | (MASK_W'(1) << sens_reg[3:0]);
        merged.obs   = (base.obs == 32'hFFFF_FFFF) ? base.obs : base.obs + 32'd1;
        merged.last  = ts_reg;
        if (chan_reg != 8'd0)
        begin
            merged.chan = chan_reg;
        end
        if (freq_reg != 16'd0)
        begin
            merged.freq = freq_reg;
        end
        if (rssi_reg < 0 && (base.rssi == 8'sd0 || rssi_reg > base.rssi))
        begin
            merged.rssi    = rssi_reg;
            merged.bsensor = 5'(sens_reg);
        end
    end

    // Sequencer: search, read, merge and write back, or drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            count_reg <= '0;
            drops_reg <= '0;
            valid_reg <= 1'b0;
            acc_reg   <= 1'b0;
            new_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start && !busy)
                    begin
                        sens_reg  <= sensor_num;
                        chan_reg  <= channel_num;
                        freq_reg  <= freq_in;
                        rssi_reg  <= rssi_in;
                        ts_reg    <= timestamp;
                        state_reg <= go ? T_SEARCH : T_DROP;
                    end
                end
                T_SEARCH:
                begin
                    if (s_done)
                    begin
                        if (s_found)
                        begin
                            idx_reg   <= s_idx;
                            new_reg   <= 1'b0;
                            state_reg <= T_READ;
                        end
                        else if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            state_reg <= T_DROP;
                        end
                        else
                        begin
                            idx_reg   <= count_reg[IDX_W-1:0];
                            new_reg   <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= T_READ;
                        end
                    end
                end
                T_READ:
                begin
                    state_reg <= T_MERGE;
                end
                T_MERGE:
                begin
                    out_reg   <= merged;
                    acc_reg   <= 1'b1;
                    valid_reg <= 1'b1;
                    state_reg <= T_IDLE;
                end
                T_DROP:
                begin
                    if (drops_reg != 32'hFFFF_FFFF)
                    begin
                        drops_reg <= drops_reg + 32'd1;
                    end
                    out_reg   <= '0;
                    acc_reg   <= 1'b0;
                    valid_reg <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // Result ports; a dropped item reports zeros for the entry fields.
    logic [IDX_W-1:0] oidx_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == T_MERGE)
        begin
            oidx_reg <= idx_reg;
        end
        else if (state_reg == T_DROP)
        begin
            oidx_reg <= '0;
        end
    end

    assign busy              = (state_reg != T_IDLE) || valid_reg;
    assign valid             = valid_reg;
    assign accepted          = acc_reg;
    assign entry_index       = 6'(oidx_reg);
    assign seen_mask         = out_reg.mask;
    assign seen_by           = 5'($countones(out_reg.mask));
    assign observation_count = out_reg.obs;
    assign first_time        = out_reg.first;
    assign last_time         = out_reg.last;
    assign stored_channel    = out_reg.chan;
    assign stored_freq       = out_reg.freq;
    assign peak_rssi         = out_reg.rssi;
    assign peak_sensor       = acc_reg ? out_reg.bsensor : 5'sd0;
    assign drop_count        = drops_reg;
endmodule

// ===== hw/rtl/komt_checker.sv =====
// Port-level checker for the merge table core, with its bind.
`timescale 1ns / 1ps
module komt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        valid,
    input logic        accepted,
    input logic [4:0]  seen_by,
    input logic [15:0] seen_mask,
    input logic [31:0] drop_count
);
    // An accepted item makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    // Results appear only while busy.
    a_res: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result while idle");
    // A merged result always has a sensor in its mask.
    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        valid && accepted |-> seen_by != 5'd0 && seen_mask != 16'd0)
        else $error("empty mask");
    // The drop counter never decreases.
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> drop_count >= $past(drop_count)) else $error("drops fell");
endmodule

bind keyed_observation_merge_table_core komt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .valid(valid),
    .accepted(accepted), .seen_by(seen_by), .seen_mask(seen_mask),
    .drop_count(drop_count)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the keyed observation merge table core.
`timescale 1ns / 1ps
module testbench;
    import komt_pkg::*;

    // Expected merge results, one per observation taken by the block.
    typedef struct packed {
        logic        accepted;
        logic [5:0]  entry_index;
        logic [15:0] seen_mask;
        logic [4:0]  seen_by;
        logic [31:0] observation_count;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [7:0]  stored_channel;
        logic [15:0] stored_freq;
        logic signed [7:0] peak_rssi;
        logic signed [4:0] peak_sensor;
        logic [31:0] drop_count;
    } merge_result_t;

    // Mirror of the station table that predicts each merge.
    class merge_scoreboard;
        logic [47:0]   keys [TABLE_DEPTH];
        entry_t        slots [TABLE_DEPTH];
        int            used;
        logic [31:0]   drops;
        merge_result_t pending [$];
        int            failures;

        function new();
            used = 0;
            drops = 0;
            failures = 0;
        endfunction

        // Predict the result of one observation taken by the block, merged or dropped.
        function void note_observation(logic [7:0] sid, logic [47:0] key, logic [7:0] chan,
                                       logic [15:0] freq, logic signed [7:0] rssi,
                                       logic [31:0] ts);
            merge_result_t r;
            int idx;
            idx = -1;
            r = '0;
            if (sid < SENSOR_COUNT)
            begin
                for (int i = 0; i < used; i++)
                    if (idx < 0 && keys[i] == key)
                        idx = i;
                if (idx < 0 && used < TABLE_DEPTH)
                begin
                    idx = used;
                    used++;
                    keys[idx] = key;
                    slots[idx] = '0;
                    slots[idx].first = ts;
                    slots[idx].bsensor = -5'sd1;
                end
            end
            if (idx < 0)
            begin
                if (drops != 32'hFFFF_FFFF)
                    drops++;
                r.drop_count = drops;
                pending.push_back(r);
                return;
            end
            slots[idx].mask[sid[3:0]] = 1'b1;
            if (slots[idx].obs != 32'hFFFF_FFFF)
                slots[idx].obs++;
            slots[idx].last = ts;
            if (chan != 0)
                slots[idx].chan = chan;
            if (freq != 0)
                slots[idx].freq = freq;
            if (rssi < 0 && (slots[idx].rssi == 0 || rssi > slots[idx].rssi))
            begin
                slots[idx].rssi = rssi;
                slots[idx].bsensor = sid[4:0];
            end
            r.accepted = 1'b1;
            r.entry_index = idx[5:0];
            r.seen_mask = slots[idx].mask;
            r.seen_by = 5'($countones(slots[idx].mask));
            r.observation_count = slots[idx].obs;
            r.first_time = slots[idx].first;
            r.last_time = slots[idx].last;
            r.stored_channel = slots[idx].chan;
            r.stored_freq = slots[idx].freq;
            r.peak_rssi = slots[idx].rssi;
            r.peak_sensor = slots[idx].bsensor;
            r.drop_count = drops;
            pending.push_back(r);
        endfunction

        // Compare one result from the block with the oldest prediction.
        function void check_result(merge_result_t got);
            merge_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result with nothing pending");
                failures++;
                return;
            end
            e = pending.pop_front();
            if (got.accepted !== e.accepted)
                begin $error("accepted exp %0d got %0d", e.accepted, got.accepted); failures++; end
            if (got.entry_index !== e.entry_index)
                begin $error("entry_index exp %0d got %0d", e.entry_index, got.entry_index); failures++; end
            if (got.seen_mask !== e.seen_mask)
                begin $error("seen_mask exp %h got %h", e.seen_mask, got.seen_mask); failures++; end
            if (got.seen_by !== e.seen_by)
                begin $error("seen_by exp %0d got %0d", e.seen_by, got.seen_by); failures++; end
            if (got.observation_count !== e.observation_count)
            begin
                $error("observation_count exp %0d got %0d", e.observation_count,
                       got.observation_count);
                failures++;
            end
            if (got.first_time !== e.first_time)
                begin $error("first_time exp %h got %h", e.first_time, got.first_time); failures++; end
            if (got.last_time !== e.last_time)
                begin $error("last_time exp %h got %h", e.last_time, got.last_time); failures++; end
            if (got.stored_channel !== e.stored_channel)
            begin
                $error("stored_channel exp %0d got %0d", e.stored_channel, got.stored_channel);
                failures++;
            end
            if (got.stored_freq !== e.stored_freq)
                begin $error("stored_freq exp %0d got %0d", e.stored_freq, got.stored_freq); failures++; end
            if (got.peak_rssi !== e.peak_rssi)
                begin $error("peak_rssi exp %0d got %0d", e.peak_rssi, got.peak_rssi); failures++; end
            if (got.peak_sensor !== e.peak_sensor)
                begin $error("peak_sensor exp %0d got %0d", e.peak_sensor, got.peak_sensor); failures++; end
            if (got.drop_count !== e.drop_count)
                begin $error("drop_count exp %0d got %0d", e.drop_count, got.drop_count); failures++; end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  sensor_num;
    logic [47:0] station_key;
    logic [7:0]  channel_num;
    logic [15:0] freq_in;
    logic signed [7:0] rssi_in;
    logic [31:0] timestamp;
    logic        valid;
    merge_result_t got;

    merge_scoreboard board;
    logic [47:0] known_keys [$];
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;
    bit          calm;

    keyed_observation_merge_table_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sensor_num(sensor_num), .station_key(station_key), .channel_num(channel_num),
        .freq_in(freq_in), .rssi_in(rssi_in), .timestamp(timestamp),
        .valid(valid), .accepted(got.accepted), .entry_index(got.entry_index),
        .seen_mask(got.seen_mask), .seen_by(got.seen_by),
        .observation_count(got.observation_count), .first_time(got.first_time),
        .last_time(got.last_time), .stored_channel(got.stored_channel),
        .stored_freq(got.stored_freq), .peak_rssi(got.peak_rssi),
        .peak_sensor(got.peak_sensor), .drop_count(got.drop_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sample results and handshakes at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n && valid)
            board.check_result(got);
        if (rst_n && ((start && !busy) || valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge clk)
    begin
        if (idle_cycles > 5000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[keyed_observation_merge_table_core] ERROR");
            $finish;
        end
    end

    // Present one observation and hold it until the block takes it.
    // Start stays high after the accepting edge; the next call either
    // replaces the item or drops start while it idles.
    task automatic send_observation(logic [7:0] sid, logic [47:0] key, logic [7:0] chan,
                                    logic [15:0] freq, logic signed [7:0] rssi,
                                    logic [31:0] ts);
        while (!calm && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        sensor_num  <= sid;
        station_key <= key;
        channel_num <= chan;
        freq_in     <= freq;
        rssi_in     <= rssi;
        timestamp   <= ts;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_observation(sid, key, chan, freq, rssi, ts);
    endtask

    // Random observation, mostly on stations already in the table.
    task automatic send_random;
        logic [7:0]  sid;
        logic [47:0] key;
        int          pick;
        pick = $urandom_range(99);
        sid = (pick < 8) ? 8'($urandom_range(255)) : 8'($urandom_range(SENSOR_COUNT - 1));
        if (known_keys.size() > 0 && $urandom_range(99) < 75)
            key = known_keys[$urandom_range(known_keys.size() - 1)];
        else
        begin
            key = 48'({$urandom, $urandom});
            if (known_keys.size() < 80)
                known_keys.push_back(key);
        end
        send_observation(sid, key,
                         ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
                         ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                         8'($urandom), $urandom);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        sensor_num = '0;
        station_key = '0;
        channel_num = '0;
        freq_in = '0;
        rssi_in = '0;
        timestamp = '0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, equal and nonnegative RSSI, bad sensors.
        send_observation(8'd0, 48'h0, 8'd0, 16'd0, 8'sd0, 32'h0);
        send_observation(8'd15, 48'hFFFF_FFFF_FFFF, 8'd255, 16'hFFFF, -8'sd128, 32'hFFFF_FFFF);
        send_observation(8'd3, 48'h0, 8'd6, 16'd2437, -8'sd60, 32'd10);
        send_observation(8'd5, 48'h0, 8'd0, 16'd0, -8'sd60, 32'd11);
        send_observation(8'd7, 48'h0, 8'd11, 16'd0, 8'sd127, 32'd12);
        send_observation(8'd9, 48'h0, 8'd0, 16'd5180, -8'sd1, 32'd13);
        send_observation(8'd16, 48'h0, 8'd1, 16'd1, -8'sd5, 32'd14);
        send_observation(8'd255, 48'hFFFF_FFFF_FFFF, 8'd1, 16'd1, -8'sd5, 32'd15);
        send_observation(8'd15, 48'hFFFF_FFFF_FFFF, 8'd0, 16'd0, -8'sd128, 32'd16);
        send_observation(8'd0, 48'hAAAA_5555_AAAA, 8'hAA, 16'h5555, -8'sd86, 32'hAAAA_AAAA);
        send_observation(8'd10, 48'h5555_AAAA_5555, 8'h55, 16'hAAAA, 8'sd85, 32'h5555_5555);

        // Fill the table, then show that a full table drops new keys.
        for (int i = 0; i < TABLE_DEPTH; i++)
            known_keys.push_back(48'h1000 + i);
        while (board.used < TABLE_DEPTH)
            send_observation(8'($urandom_range(15)), 48'h1000 + board.used, 8'd1, 16'd1,
                             -8'sd40, $urandom);
        send_observation(8'd2, 48'hDEAD_BEEF_0001, 8'd1, 16'd1, -8'sd30, 32'd99);
        send_observation(8'd4, 48'h1000, 8'd2, 16'd2, -8'sd20, 32'd100);

        // Random part with a quiet stretch of back-to-back items.
        for (int n = 0; n < 1950; n++)
        begin
            calm = (n >= 800 && n < 1100);
            send_random();
        end
        calm = 1'b0;
        start <= 1'b0;

        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 20) @(posedge clk);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("[keyed_observation_merge_table_core] OK");
        else
            $display("[keyed_observation_merge_table_core] ERROR");
        $finish;
    end
endmodule
